@@ rtl/core/rrts_pkg.sv @@
// ============================================================================
// rrts_pkg - shared types and constants of the round-robin scheduler
// Word formats, operation and status codes, and back-end sequencer states.
// ============================================================================
package rrts_pkg;

    localparam logic [15:0] QUANTUM_RESET = 16'd5;

    typedef enum logic
    {
        OP_LOAD     = 1'b0,
        OP_DISPATCH = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_LOADED     = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_IDLE       = 2'd3
    } status_t;

    typedef enum logic
    {
        BK_ACCEPT = 1'b0,
        BK_EXEC   = 1'b1
    } back_state_t;

    // Input word as seen on the push side.
    typedef struct packed
    {
        logic        operation;
        logic [7:0]  task_tag;
        logic [15:0] run_time;
    } in_word_t;

    // Result word as seen on the pop side.
    typedef struct packed
    {
        logic [1:0]  status;
        logic [7:0]  granted_tag;
        logic [15:0] slice_time;
        logic        retired;
    } out_word_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed
    {
        op_t         op;
        logic [7:0]  tag;
        logic [15:0] run_time;
    } cmd_t;

    // One entry of the task store.
    typedef struct packed
    {
        logic [7:0]  tag;
        logic [15:0] time_left;
    } slot_t;

endpackage

@@ rtl/core/rrts_front.sv @@
// ============================================================================
// rrts_front - input front end
// Accepts input words, decodes the operation and holds up to two commands.
// ============================================================================
module rrts_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rrts_pkg::in_word_t in_word,
    output logic              cmd_valid,
    output rrts_pkg::cmd_t    cmd,
    input  logic              cmd_take
);

    rrts_pkg::cmd_t slot0_reg, slot0_next;
    rrts_pkg::cmd_t slot1_reg, slot1_next;
    logic [1:0]     count_reg, count_next;
    rrts_pkg::cmd_t new_cmd;
    logic           push_ok;
    logic           take_ok;
    logic [1:0]     count_left;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot0_reg;

    // Decode the incoming word into a command.
    always_comb
    begin
        new_cmd.op       = rrts_pkg::op_t'(in_word.operation);
        new_cmd.tag      = in_word.task_tag;
        new_cmd.run_time = in_word.run_time;
    end

    always_comb
    begin
        push_ok    = push && !full;
        take_ok    = cmd_take && cmd_valid;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_left = count_reg - {1'b0, take_ok};
        if (take_ok)
        begin
            slot0_next = slot1_reg;
        end
        if (push_ok)
        begin
            if (count_left == 2'd0)
            begin
                slot0_next = new_cmd;
            end
            else
            begin
                slot1_next = new_cmd;
            end
        end
        count_next = count_left + {1'b0, push_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ rtl/core/rrts_back.sv @@
// ============================================================================
// rrts_back - scheduling back end
// Owns the task store and its pointers; executes load and dispatch commands.
// ============================================================================
module rrts_back
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         quantum,
    input  logic                cmd_valid,
    input  rrts_pkg::cmd_t      cmd,
    output logic                cmd_take,
    input  logic                res_space,
    output logic                res_valid,
    output rrts_pkg::out_word_t res_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    rrts_pkg::slot_t mem [QUEUE_DEPTH];

    rrts_pkg::back_state_t state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    rrts_pkg::slot_t       rd_data_reg;

    logic                  mem_we;
    rrts_pkg::slot_t       mem_wd;
    logic                  mem_re;
    logic                  is_empty;
    logic                  is_full;
    logic                  start;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_inc;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);
    assign start    = cmd_valid && res_space;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrts_pkg::BK_ACCEPT:
            begin
                if (start && cmd.op == rrts_pkg::OP_DISPATCH && !is_empty)
                begin
                    state_next = rrts_pkg::BK_EXEC;
                end
            end
            rrts_pkg::BK_EXEC:
            begin
                state_next = rrts_pkg::BK_ACCEPT;
            end
            default:
            begin
                state_next = rrts_pkg::BK_ACCEPT;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        cmd_take   = 1'b0;
        res_valid  = 1'b0;
        res_word   = '0;
        mem_we     = 1'b0;
        mem_wd     = '0;
        mem_re     = 1'b0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case (state_reg)
            rrts_pkg::BK_ACCEPT:
            begin
                if (start)
                begin
                    cmd_take = 1'b1;
                    if (cmd.op == rrts_pkg::OP_LOAD)
                    begin
                        res_valid = 1'b1;
                        if (is_full)
                        begin
                            res_word.status = rrts_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_word.status = rrts_pkg::ST_LOADED;
                            mem_we          = 1'b1;
                            mem_wd.tag      = cmd.tag;
                            mem_wd.time_left = cmd.run_time;
                            tail_next       = tail_inc;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                    else if (is_empty)
                    begin
                        res_valid       = 1'b1;
                        res_word.status = rrts_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // Fetch the head task; it is acted on next cycle.
                        mem_re = 1'b1;
                    end
                end
            end
            rrts_pkg::BK_EXEC:
            begin
                res_valid            = 1'b1;
                res_word.status      = rrts_pkg::ST_DISPATCHED;
                res_word.granted_tag = rd_data_reg.tag;
                head_next            = head_inc;
                if (rd_data_reg.time_left <= quantum)
                begin
                    res_word.slice_time = rd_data_reg.time_left;
                    res_word.retired    = 1'b1;
                    count_next          = count_reg - 1'b1;
                end
                else
                begin
                    // Requeue the remainder at the tail.
                    res_word.slice_time = quantum;
                    mem_we              = 1'b1;
                    mem_wd.tag          = rd_data_reg.tag;
                    mem_wd.time_left    = rd_data_reg.time_left - quantum;
                    tail_next           = tail_inc;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrts_pkg::BK_ACCEPT;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Task store: one write port at the tail, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("task count beyond queue depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> head_reg == tail_reg)
        else $error("pointers disagree with task count");

    a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rrts_pkg::BK_EXEC |-> $past(mem_re))
        else $error("dispatch executed without a head read");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_space)
        else $error("result produced with no room in result queue");

endmodule

@@ rtl/core/rrts_resq.sv @@
// ============================================================================
// rrts_resq - result queue
// Two-entry queue decoupling the back end from the pop side.
// ============================================================================
module rrts_resq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    input  rrts_pkg::out_word_t wr_word,
    output logic                space,
    output logic                empty,
    input  logic                pop,
    output rrts_pkg::out_word_t rd_word
);

    rrts_pkg::out_word_t slot0_reg, slot0_next;
    rrts_pkg::out_word_t slot1_reg, slot1_next;
    logic [1:0]          count_reg, count_next;
    logic                wr_ok;
    logic                rd_ok;
    logic [1:0]          count_left;

    assign space   = (count_reg != 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_word = slot0_reg;

    always_comb
    begin
        wr_ok      = wr_valid && space;
        rd_ok      = pop && !empty;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_left = count_reg - {1'b0, rd_ok};
        if (rd_ok)
        begin
            slot0_next = slot1_reg;
        end
        if (wr_ok)
        begin
            if (count_left == 2'd0)
            begin
                slot0_next = wr_word;
            end
            else
            begin
                slot1_next = wr_word;
            end
        end
        count_next = count_left + {1'b0, wr_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ rtl/core/round_robin_time_slice_scheduler.sv @@
// ============================================================================
// round_robin_time_slice_scheduler - round-robin scheduler with time quantum
// Keeps a circular queue of tasks and hands out one time slice per dispatch.
// ============================================================================
// Push a load word to append a task {tag, run time}, or a dispatch word to
// give the head task one slice: a task needing no more than the quantum runs
// out and retires, anything longer runs one quantum and rejoins the tail.
// Every word pushed yields exactly one result word, in order, on the pop side.
// A two-entry command queue and a two-entry result queue let both sides
// stall independently. The back end completes a load, or a dispatch that
// finds the queue empty, as it accepts the word; a dispatch that finds a
// task (the task store has a registered read port, so the head entry is
// fetched first and then retired or requeued) holds off further commands
// until it is done. Loads go at one word per cycle while the result queue
// has room. Write the quantum only while the block is idle.
// ============================================================================
module round_robin_time_slice_scheduler
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    // push side
    input  logic                push,
    output logic                full,
    input  rrts_pkg::in_word_t  in_word,
    // pop side
    output logic                empty,
    input  logic                pop,
    output rrts_pkg::out_word_t out_word,
    // quantum register
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);

    logic                quantum_reg;
    logic [15:0]         quantum_q_reg;
    logic [15:0]         quantum_q_next;
    logic                cmd_valid;
    rrts_pkg::cmd_t      cmd;
    logic                cmd_take;
    logic                res_space;
    logic                res_valid;
    rrts_pkg::out_word_t res_word;

    // Quantum register: load on write enable, hold otherwise.
    assign quantum_q_next = cfg_we ? cfg_wdata : quantum_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_q_reg <= rrts_pkg::QUANTUM_RESET;
            quantum_reg   <= 1'b0;
        end
        else
        begin
            quantum_q_reg <= quantum_q_next;
            // Flag that the quantum was rewritten since reset.
            quantum_reg   <= quantum_reg | cfg_we;
        end
    end

    // Front end: accept and decode words.
    rrts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Back end: hold the task store and execute commands.
    rrts_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .quantum   (quantum_q_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_space (res_space),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    // Result queue: present the oldest result until popped.
    rrts_resq u_resq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_word  (res_word),
        .space    (res_space),
        .empty    (empty),
        .pop      (pop),
        .rd_word  (out_word)
    );

    a_cfg_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> quantum_q_reg == $past(cfg_wdata) && quantum_reg)
        else $error("quantum write not taken");

endmodule

@@ verif/testbench.sv @@
// ============================================================================
// testbench - round-robin time-slice scheduler verification
// Push load and dispatch words through the push side under random bursts and
// gaps, and pop result words under a changing stall pattern. Predict every
// result word with a cycle-free model of the task queue and check each
// popped word field by field. Quantum changes only happen while drained.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT     = 32;    // task queue depth of the block
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving
    localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES  = 20;    // tail wait at the end of the run

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                push      = 1'b0;
    logic                full;
    rrts_pkg::in_word_t  in_word   = '0;
    logic                empty;
    logic                pop       = 1'b0;
    rrts_pkg::out_word_t out_word;
    logic                cfg_we    = 1'b0;
    logic [15:0]         cfg_wdata = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    round_robin_time_slice_scheduler i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Scheduler prediction: our own copy of the task queue and the quantum.
    // Advance it once per accepted input word, in acceptance order.
    // ------------------------------------------------------------------------
    rrts_pkg::slot_t     task_slots [SLOT_COUNT];
    int                  slot_head     = 0;
    int                  slot_tail     = 0;
    int                  tasks_queued  = 0;
    logic [15:0]         slice_quantum = rrts_pkg::QUANTUM_RESET;

    rrts_pkg::out_word_t pending_outcomes [$];   // predicted result words, oldest first
    int                  failures = 0;

    function automatic int wrap_slot(int idx);
        return (idx + 1 >= SLOT_COUNT) ? 0 : idx + 1;
    endfunction

    // Apply one input word to the queue copy and return the result it causes.
    function automatic rrts_pkg::out_word_t scheduler_outcome(rrts_pkg::in_word_t w);
        rrts_pkg::out_word_t r;
        rrts_pkg::slot_t     cur;
        r = '0;
        if (rrts_pkg::op_t'(w.operation) == rrts_pkg::OP_LOAD)
        begin
            if (tasks_queued >= SLOT_COUNT)
            begin
                r.status = rrts_pkg::ST_FULL;        // drop the task, keep state
            end
            else
            begin
                task_slots[slot_tail].tag       = w.task_tag;
                task_slots[slot_tail].time_left = w.run_time;
                slot_tail    = wrap_slot(slot_tail);
                tasks_queued = tasks_queued + 1;
                r.status     = rrts_pkg::ST_LOADED;
            end
        end
        else if (tasks_queued == 0)
        begin
            r.status = rrts_pkg::ST_IDLE;
        end
        else
        begin
            cur           = task_slots[slot_head];
            slot_head     = wrap_slot(slot_head);
            r.status      = rrts_pkg::ST_DISPATCHED;
            r.granted_tag = cur.tag;
            if (cur.time_left <= slice_quantum)
            begin
                // Run it out and retire it; zero run time retires with slice 0.
                r.slice_time = cur.time_left;
                r.retired    = 1'b1;
                tasks_queued = tasks_queued - 1;
            end
            else
            begin
                // Run one quantum and rejoin the tail. On a full queue the tail
                // slot is the head slot just freed, so the count holds.
                r.slice_time = slice_quantum;
                task_slots[slot_tail].tag       = cur.tag;
                task_slots[slot_tail].time_left = cur.time_left - slice_quantum;
                slot_tail = wrap_slot(slot_tail);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic rrts_pkg::in_word_t load_word(logic [7:0] tag, logic [15:0] run);
        rrts_pkg::in_word_t w;
        w.operation = rrts_pkg::OP_LOAD;
        w.task_tag  = tag;
        w.run_time  = run;
        return w;
    endfunction

    // Dispatch words carry random junk in the ignored fields.
    function automatic rrts_pkg::in_word_t dispatch_word();
        rrts_pkg::in_word_t w;
        w.operation = rrts_pkg::OP_DISPATCH;
        w.task_tag  = 8'($urandom);
        w.run_time  = 16'($urandom);
        return w;
    endfunction

    // Random word: run times mostly near the quantum so tasks both retire and
    // requeue, with zero and full-range times mixed in.
    function automatic rrts_pkg::in_word_t random_word(int load_pct);
        rrts_pkg::in_word_t w;
        int                 cap;
        cap = int'(slice_quantum) * 4;
        if (cap < 8)
            cap = 8;
        if (cap > 65535)
            cap = 65535;
        if ($urandom_range(1, 100) <= load_pct)
        begin
            w = load_word(8'($urandom), 16'($urandom_range(0, cap)));
            case ($urandom_range(0, 9))
                0:       w.run_time = '0;
                1, 2:    w.run_time = 16'($urandom);
                default: ;
            endcase
        end
        else
        begin
            w = dispatch_word();
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offer one word and hold it until accepted. Push stays high on return so
    // that back-to-back words go out without a bubble.
    task automatic send_word(rrts_pkg::in_word_t w);
        @(negedge clk);
        push    <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (full);
        pending_outcomes.push_back(scheduler_outcome(w));
    endtask

    // Drop push for a number of cycles (at least one).
    task automatic pause_sender(int cycles);
        @(negedge clk);
        push <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stop offering and wait until every predicted word has been popped, then
    // wait for the back end to go quiet.
    task automatic wait_drained();
        pause_sender(1);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_quantum(logic [15:0] q);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(negedge clk);
        cfg_we    <= 1'b0;
        slice_quantum = q;
    endtask

    // Send a number of words in bursts of random length; most bursts end in a
    // short gap, some run straight into the next one.
    task automatic send_bursts(int count);
        int left;
        int burst;
        int load_pct;
        left = count;
        while (left > 0)
        begin
            burst    = $urandom_range(1, 32);
            load_pct = $urandom_range(20, 80);
            while (burst > 0 && left > 0)
            begin
                send_word(random_word(load_pct));
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: stall pattern whose style is redrawn at random intervals,
    // plus a long hold-off on request from a test.
    // ------------------------------------------------------------------------
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    int   stall_style   = 0;
    int   style_left    = 0;
    int   stall_tick    = 0;
    logic stall_now;

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 80);
        end
        else
        begin
            style_left--;
        end
        stall_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            stall_now = 1'b1;
        end
        else
        begin
            case (stall_style)
                0:       stall_now = 1'b0;                           // drain freely
                1:       stall_now = ($urandom_range(0, 3) == 0);    // light stalls
                2:       stall_now = ($urandom_range(0, 3) != 0);    // heavy stalls
                default: stall_now = ((stall_tick % 3) != 0);        // periodic
            endcase
        end
        pop <= ~stall_now;
    end

    // ------------------------------------------------------------------------
    // Result check: compare each popped word with the oldest prediction.
    // ------------------------------------------------------------------------
    rrts_pkg::out_word_t want_word;

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %p",
                         $time, out_word);
                failures++;
            end
            else
            begin
                want_word = pending_outcomes.pop_front();
                check_field("status",      want_word.status,      out_word.status);
                check_field("granted_tag", want_word.granted_tag, out_word.granted_tag);
                check_field("slice_time",  want_word.slice_time,  out_word.slice_time);
                check_field("retired",     want_word.retired,     out_word.retired);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either side for too long.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d words outstanding",
                     $time, pending_outcomes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Quantum at its reset value: empty dispatch, zero run time, times below,
    // at and above the quantum, requeue order and a final empty dispatch.
    task automatic test_reset_quantum();
        send_word(load_word(8'hFF, 16'hFFFF) ^ {1'b1, 24'h0} );  // dispatch, all-ones junk
        send_word(load_word(8'h00, 16'd0));
        send_word(load_word(8'h11, 16'd4));
        send_word(load_word(8'h22, 16'd5));
        send_word(load_word(8'h33, 16'd6));
        send_word(load_word(8'h44, 16'd11));
        repeat (9) send_word(dispatch_word());
    endtask

    // Largest quantum with the largest tag and run time.
    task automatic test_field_extremes();
        set_quantum(16'hFFFF);
        send_word(load_word(8'hFF, 16'hFFFF));
        send_word(load_word(8'h80, 16'hFFFE));
        repeat (3) send_word(dispatch_word());
    endtask

    // Zero quantum: a zero-time task retires, any other gets a zero slice and
    // requeues unchanged.
    task automatic test_zero_quantum();
        set_quantum(16'd0);
        send_word(load_word(8'h01, 16'd0));
        send_word(load_word(8'hFE, 16'd7));
        repeat (3) send_word(dispatch_word());
    endtask

    // Fill the queue with long tasks, reject a load, requeue on a full queue,
    // then drain everything with the largest quantum.
    task automatic test_full_queue();
        set_quantum(16'd1);
        while (tasks_queued < SLOT_COUNT)
            send_word(load_word(8'($urandom), 16'($urandom_range(2, 65535))));
        send_word(load_word(8'h5A, 16'h1234));
        repeat (3) send_word(dispatch_word());
        send_word(load_word(8'hA5, 16'h4321));
        set_quantum(16'hFFFF);
        while (tasks_queued > 0)
            send_word(dispatch_word());
        send_word(dispatch_word());
    endtask

    // Hold the pop side off for a long stretch while words keep coming, so the
    // result queue backs up into the push side.
    task automatic test_result_backpressure();
        set_quantum(16'd3);
        hold_requests++;
        repeat (48) send_word(random_word(50));
    endtask

    // Random traffic over several quantum settings, extremes included.
    task automatic test_random_traffic();
        logic [15:0] quanta [6];
        quanta[0] = 16'd1;
        quanta[1] = 16'd7;
        quanta[2] = 16'($urandom_range(2, 40));
        quanta[3] = 16'hFFFF;
        quanta[4] = 16'($urandom_range(1, 65535));
        quanta[5] = 16'd2;
        foreach (quanta[i])
        begin
            set_quantum(quanta[i]);
            send_bursts(300);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_quantum();
        test_field_extremes();
        test_zero_quantum();
        test_full_queue();
        test_result_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
